FILE: rtl/core/dfca_pkg.sv
// Shared types, constants and tables for the density Fourier component accumulator.
`default_nettype none
package dfca_pkg;

   localparam int DEF_MAX_PARTICLES = 4096;
   localparam int PHASE_BITS        = 24;
   localparam int TRIG_BITS         = 16;
   localparam int ACC_W             = 28;
   localparam int POS_W             = 32;
   localparam int WAVE_W            = 10;
   localparam int INV_W             = 32;
   localparam int SPLIT_W           = 13;
   localparam int CSR_IDX_W         = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int TURN_W            = 48;
   localparam int TURN_HALF         = 24;
   localparam int FRAC_Q            = 30;
   localparam int MUL_A_W           = 34;
   localparam int MUL_B_W           = 30;
   localparam int RECIP_SH          = 35;
   localparam int TERMS             = 5;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [INV_W-1:0]   INV_RESET   = 32'd65536;
   localparam logic [SPLIT_W-1:0] SPLIT_RESET = 13'd4096;
   // 2*pi in Q.30 minus 2^32; the 2^32 part is added back as a plain u
   localparam logic [MUL_A_W-1:0] THETA_LO    = 34'd2451551556;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WAVE_X,
      CSR_WAVE_Y,
      CSR_WAVE_Z,
      CSR_INV_BOX_LEN,
      CSR_SPLIT_COUNT
   } csr_index_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic                    frame_end;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] real_a;
      logic signed [ACC_W-1:0] imag_a;
      logic signed [ACC_W-1:0] real_b;
      logic signed [ACC_W-1:0] imag_b;
      logic                    overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [WAVE_W-1:0] wave_x;
      logic signed [WAVE_W-1:0] wave_y;
      logic signed [WAVE_W-1:0] wave_z;
      logic [INV_W-1:0]         inv_box_len;
      logic [SPLIT_W-1:0]       split_count;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0] phase;
      logic                  use_a;
      logic                  drop;
      logic                  last;
      logic                  overflow;
   } entry_type;

   typedef struct packed {
      logic [2:0]         shift;
      logic               bypass;
      logic [MUL_A_W-1:0] recip;
   } div_info_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_THETA,
      B_SQUARE,
      B_MUL,
      B_DIV,
      B_FIN
   } back_state_type;

   // Taylor divisor D = 2^shift * odd; recip = ceil(2^35 / odd)
   function automatic div_info_type div_info(input logic cos_sel, input logic [2:0] term);
      div_info_type d;
      d = '{shift: 3'd1, bypass: 1'b1, recip: '0};
      case ({cos_sel, term})
         4'b0001: d = '{shift: 3'd1, bypass: 1'b0, recip: 34'd11453246123};
         4'b0010: d = '{shift: 3'd2, bypass: 1'b0, recip: 34'd6871947674};
         4'b0011: d = '{shift: 3'd1, bypass: 1'b0, recip: 34'd1636178018};
         4'b0100: d = '{shift: 3'd3, bypass: 1'b0, recip: 34'd3817748708};
         4'b0101: d = '{shift: 3'd1, bypass: 1'b0, recip: 34'd624722516};
         4'b1001: d = '{shift: 3'd1, bypass: 1'b1, recip: 34'd0};
         4'b1010: d = '{shift: 3'd2, bypass: 1'b0, recip: 34'd11453246123};
         4'b1011: d = '{shift: 3'd1, bypass: 1'b0, recip: 34'd2290649225};
         4'b1100: d = '{shift: 3'd3, bypass: 1'b0, recip: 34'd4908534053};
         4'b1101: d = '{shift: 3'd1, bypass: 1'b0, recip: 34'd763549742};
         default: d = '{shift: 3'd1, bypass: 1'b1, recip: 34'd0};
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/dfca_front.sv
// Front end: takes particle beats, classifies them and forms the phase.
`default_nettype none
module dfca_front import dfca_pkg::*; #(
   parameter int MAX_PARTICLES = DEF_MAX_PARTICLES
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      req_valid,
   output logic           req_stall,
   input  wire req_type   req_payload,
   output logic           push_valid,
   input  wire logic      push_full,
   output entry_type      push_entry
);

   localparam int IDX_W  = $clog2(MAX_PARTICLES + 1);
   localparam int CMP_W  = (IDX_W > SPLIT_W) ? IDX_W : SPLIT_W;
   localparam int PROD_W = POS_W + WAVE_W;
   localparam int D_W    = PROD_W + 2;
   localparam int LO_W   = TURN_HALF + INV_W;

   logic [IDX_W-1:0] index_ff, index_in;
   logic             too_many_ff, too_many_in;
   logic             s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   entry_type        meta_ff;
   req_type          pos_ff;
   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff;
   logic [TURN_W-1:0]        d_ff;
   logic [LO_W-1:0]          lo_ff;
   logic [TURN_HALF-1:0]     hi_ff;

   logic accept, keep, use_a, enter;
   logic signed [PROD_W-1:0] px, py, pz;
   logic signed [D_W-1:0]    d_sum;
   logic [LO_W-1:0]          lo_prod, hi_prod;
   logic [TURN_W-1:0]        turns;

   assign req_stall = s1_v_ff | s2_v_ff | s3_v_ff | s4_v_ff;
   assign accept    = req_valid & ~req_stall;
   assign keep      = index_ff < IDX_W'(MAX_PARTICLES);
   assign use_a     = CMP_W'(index_ff) < CMP_W'(cfg.split_count);
   // drop an extra beat outright unless it closes the frame
   assign enter     = accept & (keep | req_payload.frame_end);

   always_comb begin
      index_in    = index_ff;
      too_many_in = too_many_ff;
      if (accept) begin
         if (req_payload.frame_end) begin
            index_in    = '0;
            too_many_in = 1'b0;
         end else if (keep) begin
            index_in = index_ff + IDX_W'(1);
         end else begin
            too_many_in = 1'b1;
         end
      end
   end

   assign px      = pos_ff.pos_x * cfg.wave_x;
   assign py      = pos_ff.pos_y * cfg.wave_y;
   assign pz      = pos_ff.pos_z * cfg.wave_z;
   assign d_sum   = D_W'(px_ff) + D_W'(py_ff) + D_W'(pz_ff);
   assign lo_prod = d_ff[TURN_HALF-1:0] * cfg.inv_box_len;
   assign hi_prod = d_ff[TURN_W-1:TURN_HALF] * cfg.inv_box_len;
   assign turns   = {lo_ff[TURN_W-1:TURN_HALF] + hi_ff, lo_ff[TURN_HALF-1:0]};

   assign push_valid = s4_v_ff;
   always_comb begin
      push_entry       = meta_ff;
      push_entry.phase = turns[TURN_W-1 -: PHASE_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff    <= '0;
         too_many_ff <= 1'b0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         s4_v_ff     <= 1'b0;
      end else begin
         index_ff    <= index_in;
         too_many_ff <= too_many_in;
         s1_v_ff     <= enter;
         s2_v_ff     <= s1_v_ff;
         s3_v_ff     <= s2_v_ff;
         s4_v_ff     <= s3_v_ff | (s4_v_ff & push_full);
      end
   end

   always_ff @(posedge clock) begin
      if (enter) begin
         pos_ff            <= req_payload;
         meta_ff.phase     <= '0;
         meta_ff.use_a     <= use_a;
         meta_ff.drop      <= ~keep;
         meta_ff.last      <= req_payload.frame_end;
         meta_ff.overflow  <= too_many_ff | ~keep;
      end
      px_ff <= px;
      py_ff <= py;
      pz_ff <= pz;
      d_ff  <= TURN_W'(d_sum);
      lo_ff <= lo_prod;
      hi_ff <= hi_prod[TURN_HALF-1:0];
   end

endmodule
`default_nettype wire

FILE: rtl/core/dfca_queue.sv
// Short queue of classified particle entries between front and back.
`default_nettype none
module dfca_queue import dfca_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   output logic           push_full,
   input  wire entry_type push_entry,
   output logic           pop_valid,
   input  wire logic      pop,
   output entry_type      pop_entry
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_full = count_ff == CNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_entry = slot_ff[rd_ff];
   assign do_push   = push_valid & ~push_full;
   assign do_pop    = pop & pop_valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push)
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      if (do_pop)
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      if (do_push & ~do_pop)
         count_in = count_ff + CNT_W'(1);
      else if (do_pop & ~do_push)
         count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ff] <= push_entry;
   end

endmodule
`default_nettype wire

FILE: rtl/core/dfca_back.sv
// Back end: sine and cosine by a shared multiplier sequencer, species sums, result beat.
`default_nettype none
module dfca_back import dfca_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      pop_valid,
   output logic           pop,
   input  wire entry_type pop_entry,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_type        rsp_payload
);

   localparam int SH       = FRAC_Q - (TRIG_BITS - 1);
   localparam int MAG_W    = TRIG_BITS - 1;
   localparam int Q_W      = MUL_A_W + MUL_B_W - RECIP_SH;
   localparam int TRIG_MAX = (1 << MAG_W) - 1;

   back_state_type state_ff, state_in;
   entry_type      entry_ff;
   logic [29:0]    u_ff, th_ff, th2_ff, x_ff;
   logic           swap_ff;
   logic [1:0]     quad_ff;
   logic [30:0]    ts_ff, tc_ff;
   logic signed [32:0] s_ff, c_ff;
   logic [2:0]     term_ff;
   logic           cos_ff;
   logic signed [ACC_W-1:0] acc_ra_ff, acc_ia_ff, acc_rb_ff, acc_ib_ff;
   logic signed [ACC_W-1:0] acc_ra_in, acc_ia_in, acc_rb_in, acc_ib_in;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [63:0]        prod;
   div_info_type       dinfo;
   logic [29:0]        xs;
   logic [Q_W-1:0]     quo;
   logic signed [32:0] quo_s;
   logic [31:0]        turn;
   logic [29:0]        u_raw;
   logic [30:0]        u_mirror;
   logic [MAG_W-1:0]   mag_s, mag_c, s0, c0;
   logic signed [TRIG_BITS-1:0] sp, cp, sn, cs;
   logic               fin_go, add_a, add_b;

   function automatic logic [MAG_W-1:0] to_trig(input logic signed [32:0] v);
      logic [32:0] vu;
      logic [32:0] r;
      vu = v[32] ? '0 : v;
      r  = (vu + (33'(1) << (SH - 1))) >> SH;
      if (r > 33'(TRIG_MAX))
         r = 33'(TRIG_MAX);
      return r[MAG_W-1:0];
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:   if (pop_valid) state_in = pop_entry.drop ? B_FIN : B_THETA;
         B_THETA:  state_in = B_SQUARE;
         B_SQUARE: state_in = B_MUL;
         B_MUL:    state_in = B_DIV;
         B_DIV:    state_in = (cos_ff && term_ff == 3'(TERMS)) ? B_FIN : B_MUL;
         B_FIN:    if (fin_go) state_in = B_IDLE;
         default:  state_in = B_IDLE;
      endcase
   end

   // control outputs and multiplier operands
   always_comb begin
      pop   = 1'b0;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         B_IDLE:   pop = pop_valid;
         B_THETA:  begin
            mul_a = THETA_LO;
            mul_b = u_ff;
         end
         B_SQUARE: begin
            mul_a = MUL_A_W'(th_ff);
            mul_b = th_ff;
         end
         B_MUL:    begin
            mul_a = MUL_A_W'(cos_ff ? tc_ff : ts_ff);
            mul_b = th2_ff;
         end
         B_DIV:    begin
            mul_a = dinfo.recip;
            mul_b = xs;
         end
         default:  pop = 1'b0;
      endcase
   end

   assign prod     = mul_a * mul_b;
   assign dinfo    = div_info(cos_ff, term_ff);
   assign xs       = x_ff >> dinfo.shift;
   assign quo      = dinfo.bypass ? Q_W'(xs) : prod[63:RECIP_SH];
   assign quo_s    = signed'(33'(quo));

   assign turn     = 32'(pop_entry.phase) << (32 - PHASE_BITS);
   assign u_raw    = turn[29:0];
   assign u_mirror = (31'(1) << FRAC_Q) - 31'(u_raw);

   // fold the octant result back to the full turn
   assign mag_s = to_trig(s_ff);
   assign mag_c = to_trig(c_ff);
   assign s0    = swap_ff ? mag_c : mag_s;
   assign c0    = swap_ff ? mag_s : mag_c;
   assign sp    = signed'(TRIG_BITS'(s0));
   assign cp    = signed'(TRIG_BITS'(c0));

   always_comb begin
      case (quad_ff)
         2'd0: begin sn = sp;  cs = cp;  end
         2'd1: begin sn = cp;  cs = -sp; end
         2'd2: begin sn = -sp; cs = -cp; end
         default: begin sn = -cp; cs = sp; end
      endcase
   end

   assign fin_go = (state_ff == B_FIN) & (~entry_ff.last | ~rsp_valid_ff | ~rsp_stall);
   assign add_a  = entry_ff.use_a & ~entry_ff.drop;
   assign add_b  = ~entry_ff.use_a & ~entry_ff.drop;

   assign acc_ra_in = acc_ra_ff + (add_a ? ACC_W'(cs) : '0);
   assign acc_ia_in = acc_ia_ff + (add_a ? ACC_W'(sn) : '0);
   assign acc_rb_in = acc_rb_ff + (add_b ? ACC_W'(cs) : '0);
   assign acc_ib_in = acc_ib_ff + (add_b ? ACC_W'(sn) : '0);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_ra_ff    <= '0;
         acc_ia_ff    <= '0;
         acc_rb_ff    <= '0;
         acc_ib_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (fin_go && entry_ff.last)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
         if (fin_go) begin
            if (entry_ff.last) begin
               acc_ra_ff <= '0;
               acc_ia_ff <= '0;
               acc_rb_ff <= '0;
               acc_ib_ff <= '0;
            end else begin
               acc_ra_ff <= acc_ra_in;
               acc_ia_ff <= acc_ia_in;
               acc_rb_ff <= acc_rb_in;
               acc_ib_ff <= acc_ib_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go && entry_ff.last) begin
         rsp_ff.real_a   <= acc_ra_in;
         rsp_ff.imag_a   <= acc_ia_in;
         rsp_ff.real_b   <= acc_rb_in;
         rsp_ff.imag_b   <= acc_ib_in;
         rsp_ff.overflow <= entry_ff.overflow;
      end
      case (state_ff)
         B_IDLE: if (pop_valid) begin
            entry_ff <= pop_entry;
            quad_ff  <= turn[31:30];
            swap_ff  <= u_raw[29];
            u_ff     <= u_raw[29] ? u_mirror[29:0] : u_raw;
         end
         B_THETA:  th_ff <= u_ff + prod[61:32];
         B_SQUARE: begin
            th2_ff  <= prod[59:30];
            ts_ff   <= 31'(th_ff);
            tc_ff   <= 31'(1) << FRAC_Q;
            s_ff    <= signed'(33'(th_ff));
            c_ff    <= signed'(33'(1) << FRAC_Q);
            term_ff <= 3'd1;
            cos_ff  <= 1'b0;
         end
         B_MUL:    x_ff <= prod[59:30];
         B_DIV:    begin
            // odd terms subtract, even terms add
            if (cos_ff) begin
               tc_ff   <= 31'(quo);
               c_ff    <= term_ff[0] ? c_ff - quo_s : c_ff + quo_s;
               term_ff <= term_ff + 3'd1;
            end else begin
               ts_ff <= 31'(quo);
               s_ff  <= term_ff[0] ? s_ff - quo_s : s_ff + quo_s;
            end
            cos_ff <= ~cos_ff;
         end
         default: begin end
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/core/density_fourier_component_accumulator_core.sv
// Top level: configuration registers, front end, entry queue and back end.
// The back end takes one particle at a time through its shared multiplier (angle, square,
// then a multiply and a reciprocal divide for each of ten Taylor terms) before it takes the next.
// The front end takes no new beat until the last one has left its stages, and runs ahead of
// the back by up to two queued entries.
// Reset: synchronous; clears sums, counters and queue and loads register defaults.
`default_nettype none
module density_fourier_component_accumulator_core import dfca_pkg::*; #(
   parameter int MAX_PARTICLES = DEF_MAX_PARTICLES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_payload,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type   cfg_ff;
   logic      push_valid, push_full, pop_valid, pop;
   entry_type push_entry, pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wave_x      <= '0;
         cfg_ff.wave_y      <= '0;
         cfg_ff.wave_z      <= '0;
         cfg_ff.inv_box_len <= INV_RESET;
         cfg_ff.split_count <= SPLIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WAVE_X:      cfg_ff.wave_x      <= csr_wdata[WAVE_W-1:0];
            CSR_WAVE_Y:      cfg_ff.wave_y      <= csr_wdata[WAVE_W-1:0];
            CSR_WAVE_Z:      cfg_ff.wave_z      <= csr_wdata[WAVE_W-1:0];
            CSR_INV_BOX_LEN: cfg_ff.inv_box_len <= csr_wdata[INV_W-1:0];
            CSR_SPLIT_COUNT: cfg_ff.split_count <= csr_wdata[SPLIT_W-1:0];
            default: begin end
         endcase
      end
   end

   dfca_front #(
      .MAX_PARTICLES(MAX_PARTICLES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_entry (push_entry)
   );

   dfca_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_full (push_full),
      .push_entry(push_entry),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_entry (pop_entry)
   );

   dfca_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule
`default_nettype wire
